// ----- rtl/spbq_pkg.sv -----
package spbq_pkg;

  // Queue geometry
  localparam int NUM_BANDS  = 8;
  localparam int BAND_DEPTH = 64;

  localparam int BAND_W  = $clog2(NUM_BANDS);
  localparam int PTR_W   = $clog2(BAND_DEPTH);
  localparam int CNT_W   = $clog2(BAND_DEPTH + 1);
  // total may reach min(limit, BAND_DEPTH) + 1 across bands
  localparam int TOT_W   = $clog2(BAND_DEPTH + 2);
  localparam int LIMIT_W = 7;
  localparam int CMP_W   = (TOT_W > LIMIT_W) ? TOT_W : LIMIT_W;

  // Beat fields
  localparam int CMD_W    = 2;
  localparam int CODE_W   = 5;
  localparam int PKT_W    = 16;
  localparam int STATUS_W = 3;

  // Register port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
  localparam logic REG_IDX_LIMIT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ_LO = 2'd1,
    CMD_DEQ_HI = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 3'd0,
    ST_OVER  = 3'd1,
    ST_FULL  = 3'd2,
    ST_DEQ   = 3'd3,
    ST_PEEK  = 3'd4,
    ST_EMPTY = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } dp_cmd_t;

  // Ring pointer advance with wrap at the band depth
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(BAND_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

endpackage

// ----- rtl/spbq_ctrl.sv -----
module spbq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spbq_pkg::dp_cmd_t dp_cmd
);
  import spbq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    dp_cmd        = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        // no beat is taken while reset is held
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          dp_cmd.capture = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.execute = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          dp_cmd.load_out = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/spbq_dp.sv -----
module spbq_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spbq_pkg::dp_cmd_t                    dp_cmd,
  input  logic [spbq_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [spbq_pkg::CODE_W-1:0]   in_class_code,
  input  logic [spbq_pkg::PKT_W-1:0]           in_packet_id,
  output logic [spbq_pkg::STATUS_W-1:0]        out_status,
  output logic [spbq_pkg::PKT_W-1:0]           out_packet_out,
  output logic [spbq_pkg::BAND_W-1:0]          out_band_out,
  input  logic                                 cfg_we,
  input  logic [spbq_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [spbq_pkg::CFG_DW-1:0]          cfg_wdata,
  output logic [spbq_pkg::CFG_DW-1:0]          cfg_rdata
);
  import spbq_pkg::*;

  // Captured beat
  cmd_t                    cmd_r;
  logic [CODE_W-1:0]       code_r;
  logic [PKT_W-1:0]        pkt_r;

  // Queue state
  logic [LIMIT_W-1:0]      limit_r;
  logic [PTR_W-1:0]        head_r  [NUM_BANDS];
  logic [PTR_W-1:0]        head_nxt[NUM_BANDS];
  logic [PTR_W-1:0]        tail_r  [NUM_BANDS];
  logic [PTR_W-1:0]        tail_nxt[NUM_BANDS];
  logic [CNT_W-1:0]        count_r  [NUM_BANDS];
  logic [CNT_W-1:0]        count_nxt[NUM_BANDS];
  logic [TOT_W-1:0]        total_r, total_nxt;

  // Descriptor store
  logic [PKT_W-1:0]        mem [NUM_BANDS][BAND_DEPTH];
  logic [PKT_W-1:0]        rd_data_r;

  // Execute results
  status_t                 status_r, status_nxt;
  logic [BAND_W-1:0]       band_r, band_nxt;

  // Output register
  logic [STATUS_W-1:0]     out_status_r;
  logic [PKT_W-1:0]        out_packet_r;
  logic [BAND_W-1:0]       out_band_r;

  logic [CMP_W-1:0]        lim_ext, lim_eff;
  logic [BAND_W-1:0]       enq_band, lo_band, hi_band, deq_band;
  logic [NUM_BANDS-1:0]    nonempty;
  logic                    any_band, over, full, enq_ok, pop;

  // Beat capture
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r  <= cmd_t'(in_cmd);
      code_r <= in_class_code;
      pkt_r  <= in_packet_id;
    end
  end

  // Band from classifier code: negative or out of range goes to band 0
  always_comb begin
    enq_band = '0;
    if (!code_r[CODE_W-1] &&
        ({1'b0, code_r[CODE_W-2:0]} < CODE_W'(NUM_BANDS))) begin
      enq_band = code_r[BAND_W-1:0];
    end
  end

  // Limit checks
  assign lim_ext = CMP_W'(limit_r);
  assign lim_eff = (lim_ext > CMP_W'(BAND_DEPTH)) ? CMP_W'(BAND_DEPTH) : lim_ext;
  assign over    = CMP_W'(total_r) > lim_eff;
  assign full    = CMP_W'(count_r[enq_band]) >= lim_eff;

  // Priority encoders over non-empty bands
  always_comb begin
    lo_band = '0;
    hi_band = '0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      nonempty[i] = (count_r[i] != '0);
    end
    for (int i = NUM_BANDS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        lo_band = BAND_W'(i);
      end
    end
    for (int i = 0; i < NUM_BANDS; i++) begin
      if (nonempty[i]) begin
        hi_band = BAND_W'(i);
      end
    end
  end

  assign any_band = |nonempty;
  assign deq_band = (cmd_r == CMD_DEQ_HI) ? hi_band : lo_band;
  assign enq_ok   = (cmd_r == CMD_ENQ) && !over && !full;
  assign pop      = ((cmd_r == CMD_DEQ_LO) || (cmd_r == CMD_DEQ_HI)) && any_band;

  // Status and band of the result
  always_comb begin
    if (cmd_r == CMD_ENQ) begin
      status_nxt = over ? ST_OVER : (full ? ST_FULL : ST_ENQ);
      band_nxt   = enq_band;
    end else if (!any_band) begin
      status_nxt = ST_EMPTY;
      band_nxt   = '0;
    end else begin
      status_nxt = (cmd_r == CMD_PEEK) ? ST_PEEK : ST_DEQ;
      band_nxt   = deq_band;
    end
  end

  // Pointer and count updates
  always_comb begin
    for (int i = 0; i < NUM_BANDS; i++) begin
      head_nxt[i]  = head_r[i];
      tail_nxt[i]  = tail_r[i];
      count_nxt[i] = count_r[i];
    end
    total_nxt = total_r;
    if (dp_cmd.execute && enq_ok) begin
      tail_nxt[enq_band]  = next_slot(tail_r[enq_band]);
      count_nxt[enq_band] = count_r[enq_band] + 1'b1;
      total_nxt           = total_r + 1'b1;
    end
    if (dp_cmd.execute && pop) begin
      head_nxt[deq_band]  = next_slot(head_r[deq_band]);
      count_nxt[deq_band] = count_r[deq_band] - 1'b1;
      if (total_r != '0) begin
        total_nxt = total_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
      total_r <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        head_r[i]  <= head_nxt[i];
        tail_r[i]  <= tail_nxt[i];
        count_r[i] <= count_nxt[i];
      end
      total_r <= total_nxt;
      if (cfg_we && (cfg_addr[2] == REG_IDX_LIMIT)) begin
        limit_r <= cfg_wdata[LIMIT_W-1:0];
      end
    end
  end

  assign cfg_rdata = (cfg_addr[2] == REG_IDX_LIMIT) ? CFG_DW'(limit_r) : '0;

  // Store: at most one write and one registered read per item
  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      if (enq_ok) begin
        mem[enq_band][tail_r[enq_band]] <= pkt_r;
      end
      rd_data_r <= mem[deq_band][head_r[deq_band]];
      status_r  <= status_nxt;
      band_r    <= band_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (dp_cmd.load_out) begin
      out_status_r <= status_r;
      out_band_r   <= band_r;
      if ((status_r == ST_DEQ) || (status_r == ST_PEEK)) begin
        out_packet_r <= rd_data_r;
      end else begin
        out_packet_r <= '0;
      end
    end
  end

  assign out_status     = out_status_r;
  assign out_packet_out = out_packet_r;
  assign out_band_out   = out_band_r;

endmodule

// ----- rtl/strict_priority_band_queue.sv -----
// Channel   Direction  Handshake              Beat contents
// in_       input      in_valid / in_ready    cmd, class_code, packet_id
// out_      output     out_valid / out_ready  status, packet_out, band_out
// cfg_      APB        psel, penable, pready  packet_limit at byte address 0
//
// Each item passes through capture, execute (band pick, limit checks,
// store write and registered read) and result load. The capture stage
// and the registered store read make these separate steps.
// rst_n is synchronous: all bands empty, limit back to 64, no beat pending.
// A result waits in the output register; the next item is taken meanwhile,
// and the result load stalls, and no further item is taken, while out_ready stays low.
module strict_priority_band_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [spbq_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [spbq_pkg::CODE_W-1:0]   in_class_code,
  input  logic [spbq_pkg::PKT_W-1:0]           in_packet_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [spbq_pkg::STATUS_W-1:0]        out_status,
  output logic [spbq_pkg::PKT_W-1:0]           out_packet_out,
  output logic [spbq_pkg::BAND_W-1:0]          out_band_out,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [spbq_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [spbq_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [spbq_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                 cfg_pready
);
  import spbq_pkg::*;

  dp_cmd_t dp_cmd;
  logic    cfg_we;

  // Zero-wait register port
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  spbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  spbq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .in_cmd         (in_cmd),
    .in_class_code  (in_class_code),
    .in_packet_id   (in_packet_id),
    .out_status     (out_status),
    .out_packet_out (out_packet_out),
    .out_band_out   (out_band_out),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_paddr),
    .cfg_wdata      (cfg_pwdata),
    .cfg_rdata      (cfg_prdata)
  );

endmodule
